// File: rtl/normal_affinity_edge_weights_top_assert.svh
// Assertion macros used by the checker file of the edge weight block.
`ifndef NORMAL_AFFINITY_EDGE_WEIGHTS_TOP_ASSERT_SVH
`define NORMAL_AFFINITY_EDGE_WEIGHTS_TOP_ASSERT_SVH

// Clocked assertion that is off while reset is held.
`define NAEW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold whenever a result is offered.
`define NAEW_ASSERT_OUT(lbl, prop, msg) \
    `NAEW_ASSERT(lbl, out_valid |-> (prop), msg)

`endif

// File: rtl/naew_pkg.sv
// ----------------------------------------------------------------------------
// naew_pkg
// Types, constants and table builder for the normal affinity edge weights.
// ----------------------------------------------------------------------------
package naew_pkg;

    localparam int MAX_WIDTH_DEF       = 1024;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int NRM_W    = 16;
    localparam int WEIGHT_W = 17;
    localparam int ROW_W    = 16;
    localparam int PCOL_W   = 10;
    localparam int IWID_W   = 11;
    localparam int INV_W    = 24;
    localparam int CFG_W    = 24;
    localparam int CFGI_W   = 2;

    localparam logic [CFGI_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_INV_SIGMA_SQ = 2'd1;
    localparam logic [CFGI_W-1:0] REG_ZERO_SIGMA   = 2'd2;

    localparam logic [IWID_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [INV_W-1:0]  INV_SIGMA_SQ_RST = 24'd65536;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } nrm_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } aff_rsp_t;

    // Division by the series term number, each arm by a literal.
    function automatic logic [63:0] div_term(input logic [63:0] u, input int n);
        logic [63:0] q;
        case (n)
            1:       q = u;
            2:       q = u / 2;
            3:       q = u / 3;
            4:       q = u / 4;
            5:       q = u / 5;
            6:       q = u / 6;
            7:       q = u / 7;
            8:       q = u / 8;
            9:       q = u / 9;
            10:      q = u / 10;
            11:      q = u / 11;
            12:      q = u / 12;
            13:      q = u / 13;
            14:      q = u / 14;
            15:      q = u / 15;
            16:      q = u / 16;
            17:      q = u / 17;
            18:      q = u / 18;
            19:      q = u / 19;
            default: q = u / 20;
        endcase
        return q;
    endfunction

    // Entry i of the exp table, Q1.16; step is 2^36 over the table depth.
    // Evaluated only at elaboration.
    function automatic logic [WEIGHT_W-1:0] exp_entry(input int i, input logic [63:0] step);
        logic [63:0] u;
        logic signed [63:0] r;
        logic [63:0] e;
        logic [63:0] v;
        u = 64'd1 << 32;
        r = 64'sd1 <<< 32;
        e = 64'd1 << 32;
        for (int n = 1; n <= 20; n++) begin
            u = div_term((u * step) >> 32, n);
            if ((n % 2) == 1) r = r - $signed(u);
            else r = r + $signed(u);
        end
        if (r < 0) r = 0;
        for (int k = 0; k < i; k++) begin
            e = (e * $unsigned(r) + (64'd1 << 31)) >> 32;
        end
        v = (e + 64'd32768) >> 16;
        return v[WEIGHT_W-1:0];
    endfunction

endpackage

// File: rtl/naew_affinity.sv
// ----------------------------------------------------------------------------
// naew_affinity
// Iterative affinity unit: one shared multiplier computes exp(-d*d/sigma^2).
// ----------------------------------------------------------------------------
module naew_affinity #(
    parameter int EXP_TABLE_DEPTH = naew_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  naew_pkg::nrm_t            p,
    input  naew_pkg::nrm_t            q,
    input  logic [naew_pkg::INV_W-1:0] inv_sigma_sq,
    output naew_pkg::aff_rsp_t        rsp
);
    import naew_pkg::*;

    localparam int AW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [63:0] EXP_STEP = (64'd16 << 32) / EXP_TABLE_DEPTH;

    typedef enum logic [9:0] {
        U_IDLE = 10'b0000000001,
        U_DOT0 = 10'b0000000010,
        U_DOT1 = 10'b0000000100,
        U_DOT2 = 10'b0000001000,
        U_ABS  = 10'b0000010000,
        U_SQ   = 10'b0000100000,
        U_XL   = 10'b0001000000,
        U_XH   = 10'b0010000000,
        U_IDX  = 10'b0100000000,
        U_LOOK = 10'b1000000000
    } ustate_t;

    ustate_t state_reg, state_next;

    logic signed [34:0] acc_reg;
    logic [19:0]        a_reg;
    logic [39:0]        sq_reg;
    logic [43:0]        xacc_reg;
    logic [63:0]        x_reg;
    logic [IW-1:0]      idx_reg;
    logic               sat_reg;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] prod;
    logic signed [35:0] dd;
    logic [35:0]        mag;
    logic [35:0]        rnd;
    logic [57:0]        idx_sum;

    logic [WEIGHT_W-1:0] exp_tab [EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [WEIGHT_W-1:0] EV = exp_entry(gi, EXP_STEP);
        assign exp_tab[gi] = EV;
    end

    // Operand select for the single shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            U_DOT0:  begin mul_a = 33'(p.x); mul_b = 25'(q.x); end
            U_DOT1:  begin mul_a = 33'(p.y); mul_b = 25'(q.y); end
            U_DOT2:  begin mul_a = 33'(p.z); mul_b = 25'(q.z); end
            U_SQ:    begin mul_a = $signed({13'd0, a_reg}); mul_b = $signed({5'd0, a_reg}); end
            U_XL:    begin mul_a = $signed({13'd0, sq_reg[19:0]});
                           mul_b = $signed({1'b0, inv_sigma_sq}); end
            U_XH:    begin mul_a = $signed({13'd0, sq_reg[39:20]});
                           mul_b = $signed({1'b0, inv_sigma_sq}); end
            U_IDX:   begin mul_a = $signed({1'b0, x_reg[51:20]});
                           mul_b = 25'(EXP_TABLE_DEPTH); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign dd      = (36'sd1 <<< 30) - 36'(acc_reg);
    assign mag     = (dd < 0) ? $unsigned(-dd) : $unsigned(dd);
    assign rnd     = mag + 36'd4096;
    assign idx_sum = $unsigned(prod) + (58'd1 << 31);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:  if (start) state_next = U_DOT0;
            U_DOT0:  state_next = U_DOT1;
            U_DOT1:  state_next = U_DOT2;
            U_DOT2:  state_next = U_ABS;
            U_ABS:   state_next = U_SQ;
            U_SQ:    state_next = U_XL;
            U_XL:    state_next = U_XH;
            U_XH:    state_next = U_IDX;
            U_IDX:   state_next = U_LOOK;
            U_LOOK:  state_next = start ? U_DOT0 : U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= U_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        case (state_reg)
            U_DOT0:  acc_reg <= prod[34:0];
            U_DOT1:  acc_reg <= acc_reg + prod[34:0];
            U_DOT2:  acc_reg <= acc_reg + prod[34:0];
            U_ABS:   a_reg <= rnd[32:13];
            U_SQ:    sq_reg <= prod[39:0];
            U_XL:    xacc_reg <= prod[43:0];
            U_XH:    x_reg <= {prod[43:0], 20'd0} + 64'(xacc_reg);
            U_IDX:
            begin
                idx_reg <= idx_sum[32 +: IW];
                sat_reg <= |x_reg[63:52];
            end
            default: ;
        endcase
    end

    always_comb begin
        rsp.done   = (state_reg == U_LOOK);
        rsp.weight = '0;
        if (!sat_reg && (idx_reg < IW'(EXP_TABLE_DEPTH))) begin
            rsp.weight = exp_tab[idx_reg[AW-1:0]];
        end
    end

endmodule

// File: rtl/normal_affinity_edge_weights_top.sv
// Sequence: an accepted pixel passes the line memory states (read up, read up-right,
// write), then the shared affinity unit evaluates its four neighbours one after another,
// then the output load state offers the result and waits while the result side stalls;
// the block then returns to idle with ready high and takes no new pixel before that.
// Reset: registers go to width 640, inv_sigma_sq 1.0, zero_sigma 0; counters clear;
// the line memory is not cleared and holds no data until written.
// ----------------------------------------------------------------------------
// normal_affinity_edge_weights_top
// Raster-order normal stream to four backward Gaussian affinity weights.
// ----------------------------------------------------------------------------
module normal_affinity_edge_weights_top #(
    parameter int MAX_WIDTH       = naew_pkg::MAX_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = naew_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [naew_pkg::CFGI_W-1:0]    cfg_index,
    input  logic [naew_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [naew_pkg::NRM_W-1:0] normal_x,
    input  logic signed [naew_pkg::NRM_W-1:0] normal_y,
    input  logic signed [naew_pkg::NRM_W-1:0] normal_z,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [naew_pkg::WEIGHT_W-1:0]  weight_left,
    output logic [naew_pkg::WEIGHT_W-1:0]  weight_up_left,
    output logic [naew_pkg::WEIGHT_W-1:0]  weight_up,
    output logic [naew_pkg::WEIGHT_W-1:0]  weight_up_right,
    output logic [naew_pkg::PCOL_W-1:0]    pixel_column,
    output logic [naew_pkg::ROW_W-1:0]     pixel_row
);
    import naew_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = (COL_W + 1 > IWID_W) ? COL_W + 1 : IWID_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD_UP = 6'b000010,
        S_RD_UR = 6'b000100,
        S_WR    = 6'b001000,
        S_CALC  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [IWID_W-1:0] image_width_reg;
    logic [INV_W-1:0]  inv_sigma_sq_reg;
    logic              zero_sigma_reg;

    logic [COL_W-1:0]  column_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [1:0]        k_reg;
    logic              out_valid_reg;

    nrm_t cur_reg, prev_reg, ul_reg, up_reg, ur_reg;
    logic [WEIGHT_W-1:0] w_reg [4];

    nrm_t line_mem [MAX_WIDTH];
    nrm_t rdata_reg;
    logic [COL_W-1:0] raddr;

    nrm_t     q_sel;
    logic     aff_start;
    aff_rsp_t aff_rsp;

    logic [EW-1:0] img_ext, w_eff, col_p1;
    logic          wrap, ur_in, out_free;
    logic [31:0]   col_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign img_ext = EW'(image_width_reg);
    assign w_eff   = (img_ext == '0) ? EW'(1) :
                     (img_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : img_ext;
    assign col_p1  = EW'(col_reg) + EW'(1);
    assign wrap    = (col_p1 >= w_eff);
    assign ur_in   = !wrap;
    assign col_ext = 32'(col_reg);

    assign raddr = (state_reg == S_RD_UR) ? COL_W'(col_p1) : col_reg;

    always_ff @(posedge clk) begin
        if (state_reg == S_WR) begin
            line_mem[col_reg] <= cur_reg;
        end
        rdata_reg <= line_mem[raddr];
    end

    always_comb begin
        case (k_reg)
            2'd0:    q_sel = prev_reg;
            2'd1:    q_sel = ul_reg;
            2'd2:    q_sel = up_reg;
            default: q_sel = ur_reg;
        endcase
    end

    assign aff_start = (state_reg == S_WR) ||
                       ((state_reg == S_CALC) && aff_rsp.done && (k_reg != 2'd3));

    naew_affinity #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_affinity (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (aff_start),
        .p           (cur_reg),
        .q           (q_sel),
        .inv_sigma_sq(inv_sigma_sq_reg),
        .rsp         (aff_rsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_RD_UP;
            S_RD_UP: state_next = S_RD_UR;
            S_RD_UR: state_next = S_WR;
            S_WR:    state_next = S_CALC;
            S_CALC:  if (aff_rsp.done && (k_reg == 2'd3)) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            image_width_reg  <= IMAGE_WIDTH_RST;
            inv_sigma_sq_reg <= INV_SIGMA_SQ_RST;
            zero_sigma_reg   <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            k_reg            <= 2'd0;
            out_valid_reg    <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IWID_W-1:0];
                    REG_INV_SIGMA_SQ: inv_sigma_sq_reg <= cfg_data[INV_W-1:0];
                    REG_ZERO_SIGMA:   zero_sigma_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (state_reg == S_WR) begin
                k_reg <= 2'd0;
            end
            else if ((state_reg == S_CALC) && aff_rsp.done) begin
                k_reg <= k_reg + 2'd1;
            end
            if ((state_reg == S_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
                if (wrap) begin
                    column_count_reg <= '0;
                    if (row_count_reg != '1) row_count_reg <= row_count_reg + 1'b1;
                end
                else begin
                    column_count_reg <= COL_W'(col_p1);
                end
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            // A frame start restarts the raster position before this pixel.
            if ((state_reg == S_IDLE) && in_valid && frame_start) begin
                column_count_reg <= '0;
                row_count_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if ((state_reg == S_IDLE) && in_valid) begin
            cur_reg <= '{x: normal_x, y: normal_y, z: normal_z};
            col_reg <= frame_start ? '0 : column_count_reg;
            row_reg <= frame_start ? '0 : row_count_reg;
        end
        if (state_reg == S_RD_UR) begin
            up_reg <= rdata_reg;
        end
        if (state_reg == S_WR) begin
            ur_reg <= rdata_reg;
        end
        if ((state_reg == S_CALC) && aff_rsp.done) begin
            w_reg[k_reg] <= aff_rsp.weight;
        end
        if ((state_reg == S_DONE) && out_free) begin
            ul_reg          <= up_reg;
            prev_reg        <= cur_reg;
            weight_left     <= (!zero_sigma_reg && (col_reg != '0)) ? w_reg[0] : '0;
            weight_up_left  <= (!zero_sigma_reg && (row_reg != '0) && (col_reg != '0))
                               ? w_reg[1] : '0;
            weight_up       <= (!zero_sigma_reg && (row_reg != '0)) ? w_reg[2] : '0;
            weight_up_right <= (!zero_sigma_reg && (row_reg != '0) && ur_in) ? w_reg[3] : '0;
            pixel_column    <= col_ext[PCOL_W-1:0];
            pixel_row       <= row_reg;
        end
    end

endmodule

// File: rtl/naew_checker.sv
// ----------------------------------------------------------------------------
// naew_checker
// Port-level checks of the edge weight block, bound to its top level.
// ----------------------------------------------------------------------------
`include "normal_affinity_edge_weights_top_assert.svh"

module naew_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] weight_left,
    input logic [16:0] weight_up_left,
    input logic [16:0] weight_up,
    input logic [16:0] weight_up_right,
    input logic [9:0]  pixel_column,
    input logic [15:0] pixel_row
);

    // A pixel occupies the block after its transaction, so ready drops on acceptance.
    `NAEW_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")

    // Weights never exceed one in Q1.16.
    `NAEW_ASSERT_OUT(a_weight_range, (weight_left <= 17'd65536) && (weight_up_left <= 17'd65536) && (weight_up <= 17'd65536) && (weight_up_right <= 17'd65536), "weight above one")

    // The first row has no upper neighbours.
    `NAEW_ASSERT_OUT(a_top_row, (pixel_row != 16'd0) || ((weight_up == 17'd0) && (weight_up_left == 17'd0) && (weight_up_right == 17'd0)), "upper weight in first row")

    // A stalled result stays offered.
    `NAEW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")

endmodule

bind normal_affinity_edge_weights_top naew_checker u_naew_checker (.*);

// File: tb/tb_normal_affinity_edge_weights_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_affinity_edge_weights_top
// Self-checking bench for the backward-neighbour affinity weight block. A directed
// table and a random normal stream run under several register settings; results are
// checked against a local fixed-point predictor or, for typed rows, the table weights.
// ----------------------------------------------------------------------------
module tb_normal_affinity_edge_weights_top;

    import naew_pkg::*;

    localparam int LINE_DEPTH  = 1024;
    localparam int EXP_DEPTH   = 256;
    localparam int DRAIN_WAIT  = 60;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [WEIGHT_W-1:0] wl;
        logic [WEIGHT_W-1:0] wul;
        logic [WEIGHT_W-1:0] wu;
        logic [WEIGHT_W-1:0] wur;
        logic [PCOL_W-1:0]   col;
        logic [ROW_W-1:0]    row;
    } pixel_weights_t;

    typedef struct {
        bit          new_cfg;
        int          cw;
        int          ci;
        bit          cz;
        shortint     x;
        shortint     y;
        shortint     z;
        bit          fs;
        bit          typed;
        int          wl;
        int          wul;
        int          wu;
        int          wur;
    } pixel_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFGI_W-1:0]    cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                 frame_start;
    logic                 out_valid;
    logic                 out_ready;
    logic [WEIGHT_W-1:0]  weight_left;
    logic [WEIGHT_W-1:0]  weight_up_left;
    logic [WEIGHT_W-1:0]  weight_up;
    logic [WEIGHT_W-1:0]  weight_up_right;
    logic [PCOL_W-1:0]    pixel_column;
    logic [ROW_W-1:0]     pixel_row;

    // Predictor state.
    logic [WEIGHT_W-1:0] exp_lut [EXP_DEPTH];
    nrm_t                line_normals [LINE_DEPTH];
    nrm_t                left_normal;
    nrm_t                diag_normal;
    int unsigned         col_count;
    int unsigned         row_count;
    int unsigned         width_reg;
    longint unsigned     inv_sigma_reg;
    bit                  zero_sigma_reg;

    pixel_weights_t      pending_weights [$];
    int                  errors;
    int                  pixels_sent;
    int                  results_seen;
    int                  settings_used;
    int                  stall_left;
    int                  idle_cycles;
    bit                  quiet;

    normal_affinity_edge_weights_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .normal_x        (normal_x),
        .normal_y        (normal_y),
        .normal_z        (normal_z),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .weight_left     (weight_left),
        .weight_up_left  (weight_up_left),
        .weight_up       (weight_up),
        .weight_up_right (weight_up_right),
        .pixel_column    (pixel_column),
        .pixel_row       (pixel_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The exp table: a 21-term series gives the ratio between entries, and
    // each entry is the previous one times that ratio, rounded.
    function automatic void build_exp_lut();
        longint unsigned step;
        longint unsigned term;
        longint          ratio;
        longint unsigned acc;
        step  = (64'd16 << 32) / EXP_DEPTH;
        term  = 64'd1 << 32;
        ratio = 64'sd1 <<< 32;
        acc   = 64'd1 << 32;
        for (int n = 1; n <= 20; n++)
        begin
            term = ((term * step) >> 32) / n;
            if (n % 2 == 1)
                ratio = ratio - longint'(term);
            else
                ratio = ratio + longint'(term);
        end
        if (ratio < 0)
            ratio = 0;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            exp_lut[i] = WEIGHT_W'((acc + 64'd32768) >> 16);
            acc = (acc * longint'(ratio) + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic logic [WEIGHT_W-1:0] edge_affinity(input nrm_t p, input nrm_t q);
        longint          dot;
        longint          diff;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned expo;
        longint unsigned idx;
        if (zero_sigma_reg)
            return '0;
        dot = longint'(p.x) * longint'(q.x) + longint'(p.y) * longint'(q.y)
            + longint'(p.z) * longint'(q.z);
        diff = 2 * ((64'sd1 <<< 30) - dot);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        a    = (mag + 64'd8192) >> 14;
        expo = a * a * inv_sigma_reg;
        if (expo >= (64'd16 << 48))
            return '0;
        idx = (((expo >> 20) * EXP_DEPTH) + (64'd1 << 31)) >> 32;
        if (idx >= EXP_DEPTH)
            return '0;
        return exp_lut[idx];
    endfunction

    function automatic pixel_weights_t predict_weights(input nrm_t cur, input bit fs);
        pixel_weights_t r;
        int unsigned    w;
        int unsigned    col;
        nrm_t           above;
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
        if (fs)
        begin
            col_count = 0;
            row_count = 0;
        end
        col   = (col_count >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_count;
        above = line_normals[col];
        r     = '0;
        if (col > 0)
            r.wl = edge_affinity(cur, left_normal);
        if (row_count > 0)
        begin
            r.wu = edge_affinity(cur, above);
            if (col > 0)
                r.wul = edge_affinity(cur, diag_normal);
            if (col + 1 < w)
                r.wur = edge_affinity(cur, line_normals[col + 1]);
        end
        r.col = PCOL_W'(col);
        r.row = ROW_W'(row_count);
        diag_normal       = above;
        line_normals[col] = cur;
        left_normal       = cur;
        if (col + 1 >= w)
        begin
            col_count = 0;
            if (row_count < 65535)
                row_count++;
        end
        else
        begin
            col_count = col + 1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 65)
            return 0;
        else if (p < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 70);
    endfunction

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg      = value & 32'h7FF;
            REG_INV_SIGMA_SQ: inv_sigma_reg  = value & 32'hFFFFFF;
            REG_ZERO_SIGMA:   zero_sigma_reg = value & 1;
            default: ;
        endcase
    endtask

    // Waits until every result is back, then lets the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic load_settings(input int w, input int inv, input bit zs);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_INV_SIGMA_SQ, inv);
        write_reg(REG_ZERO_SIGMA, zs);
        settings_used++;
    endtask

    task automatic send_pixel(input nrm_t n, input bit fs, input bit typed,
                              input int wl, input int wul, input int wu, input int wur);
        pixel_weights_t r;
        int             gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r = predict_weights(n, fs);
        if (typed)
        begin
            r.wl  = WEIGHT_W'(wl);
            r.wul = WEIGHT_W'(wul);
            r.wu  = WEIGHT_W'(wu);
            r.wur = WEIGHT_W'(wur);
        end
        pending_weights.push_back(r);
        in_valid    <= 1'b1;
        normal_x    <= n.x;
        normal_y    <= n.y;
        normal_z    <= n.z;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_sent++;
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result side: random backpressure with occasional long holds, ready high in quiet phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(20, 70);
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) < 75);
        end
    end

    always @(posedge clk)
    begin
        pixel_weights_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_weights.size() == 0)
            begin
                $display("%0t: result with no pixel outstanding", $time);
                errors++;
            end
            else
            begin
                e = pending_weights.pop_front();
                check_field("weight_left", e.wl, weight_left);
                check_field("weight_up_left", e.wul, weight_up_left);
                check_field("weight_up", e.wu, weight_up);
                check_field("weight_up_right", e.wur, weight_up_right);
                check_field("pixel_column", e.col, pixel_column);
                check_field("pixel_row", e.row, pixel_row);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    pixel_row_t dir_rows [16] = '{
        '{0, 0, 0, 0,  32767, -32768, 0,      1, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0, -32768,  32767, 32767,  0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0,  0,      0,      0,     0, 0, 0, 0, 0, 0},
        '{1, 3, 0, 0,  23170,  23170,  0,     1, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0,  1,      2,      3,     0, 1, 65536, 0, 0, 0},
        '{0, 0, 0, 0, -5,      0,      32767, 0, 1, 65536, 0, 0, 0},
        '{0, 0, 0, 0,  0,      0,      32767, 0, 1, 0, 0, 65536, 65536},
        '{0, 0, 0, 0, -32768, -32768, -32768, 0, 1, 65536, 65536, 65536, 65536},
        '{0, 0, 0, 0,  32767,  32767,  32767, 0, 1, 65536, 65536, 65536, 0},
        '{1, 2047, 16777215, 0, 0, 0, 32767,  1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0,  0,      0,      32767, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0,  0,      32767,  0,     0, 0, 0, 0, 0, 0},
        '{1, 0, 65536, 1, 0,   0,      32767, 1, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0,  0,      0,      32767, 0, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0,  100,   -100,    0,     0, 1, 0, 0, 0, 0}
    };

    int phase_width [8] = '{5, 1, 2, 17, 1024, 64, 3, 9};
    int phase_items [8] = '{100, 80, 90, 100, 40, 100, 90, 80};

    initial
    begin
        nrm_t base;
        nrm_t n;
        int   inv;
        int   mode;
        bit   fs;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        normal_x    = '0;
        normal_y    = '0;
        normal_z    = '0;
        frame_start = 1'b0;
        quiet       = 1'b0;
        errors      = 0;
        pixels_sent = 0;
        results_seen = 0;
        settings_used = 1;
        idle_cycles = 0;
        col_count   = 0;
        row_count   = 0;
        width_reg      = IMAGE_WIDTH_RST;
        inv_sigma_reg  = INV_SIGMA_SQ_RST;
        zero_sigma_reg = 1'b0;
        build_exp_lut();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].new_cfg)
                load_settings(dir_rows[i].cw, dir_rows[i].ci, dir_rows[i].cz);
            n.x = dir_rows[i].x;
            n.y = dir_rows[i].y;
            n.z = dir_rows[i].z;
            send_pixel(n, dir_rows[i].fs, dir_rows[i].typed, dir_rows[i].wl,
                       dir_rows[i].wul, dir_rows[i].wu, dir_rows[i].wur);
        end

        // Every phase starts a new frame, so the line memory is always
        // refilled before a row above is read.
        foreach (phase_width[p])
        begin
            case (p % 4)
                0:       inv = 65536;
                1:       inv = $urandom_range(0, 16777215);
                2:       inv = $urandom_range(0, 4096);
                default: inv = $urandom_range(65536, 1048576);
            endcase
            if (p == 6)
                inv = 16777215;
            if (p == 7)
                inv = 0;
            load_settings(phase_width[p], inv, p == 5);
            quiet = (p == 2);
            base.x = NRM_W'($urandom);
            base.y = NRM_W'($urandom);
            base.z = NRM_W'($urandom);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                mode = $urandom_range(0, 99);
                if (mode < 55)
                begin
                    n.x = base.x + NRM_W'($urandom_range(0, 1200)) - NRM_W'(600);
                    n.y = base.y + NRM_W'($urandom_range(0, 1200)) - NRM_W'(600);
                    n.z = base.z + NRM_W'($urandom_range(0, 1200)) - NRM_W'(600);
                end
                else if (mode < 85)
                begin
                    n.x = NRM_W'($urandom);
                    n.y = NRM_W'($urandom);
                    n.z = NRM_W'($urandom);
                end
                else
                begin
                    n.x = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
                    n.y = ($urandom_range(0, 1)) ? 16'sh0000 : 16'shFFFF;
                    n.z = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
                end
                if ($urandom_range(0, 9) == 0)
                    base = n;
                fs = (k == 0) || ($urandom_range(0, 59) == 0);
                send_pixel(n, fs, 1'b0, 0, 0, 0, 0);
            end
            quiet = 1'b0;
        end

        drain();
        if (pending_weights.size() != 0)
            errors++;
        $display("Sent %0d pixels under %0d register settings, %0d results checked.",
                 pixels_sent, settings_used, results_seen);
        $display("Widths 0 to 2047, sigma extremes and zero sigma exercised; %0d errors.",
                 errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/naew_pkg.sv
rtl/naew_affinity.sv
rtl/normal_affinity_edge_weights_top.sv
rtl/naew_checker.sv
tb/tb_normal_affinity_edge_weights_top.sv
